// File: src/sha1_block_absorber_core_defines.svh
`ifndef SHA1_BLOCK_ABSORBER_CORE_DEFINES_SVH
`define SHA1_BLOCK_ABSORBER_CORE_DEFINES_SVH

// Concurrent checks on clk, held off during reset.
`define SHA1BA_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`define SHA1BA_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: src/sha1ba_pkg.sv
`timescale 1ns / 1ps

package sha1ba_pkg;

	localparam int unsigned NUM_WORDS = 5;
	localparam int unsigned BLK_WORDS = 16;
	localparam int unsigned ROUNDS    = 80;

	typedef logic [31:0] word_t;
	typedef logic [2:0]  widx_t;
	typedef logic [6:0]  rnd_t;
	typedef logic [5:0]  pos_t;
	typedef logic [3:0]  maddr_t;

	localparam widx_t  LAST_IDX   = 3'd4;
	localparam widx_t  LOAD_DONE  = 3'd5;
	localparam pos_t   LAST_POS   = 6'd63;
	localparam rnd_t   LAST_RND   = 7'd79;
	localparam maddr_t LAST_MWORD = 4'd15;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_FRD,
		ST_FWR
	} state_t;

	typedef enum logic {
		KIND_START = 1'b0,
		KIND_DATA  = 1'b1
	} kind_t;

	typedef struct packed {
		word_t a;
		word_t b;
		word_t c;
		word_t d;
		word_t e;
	} work_t;

	typedef struct packed {
		logic  load_en;
		widx_t load_idx;
		logic  round_en;
		rnd_t  rnd;
	} rctl_t;

	function automatic word_t iv_word(widx_t idx);
		word_t v;
		case (idx)
			3'd0: v = 32'h67452301;
			3'd1: v = 32'hEFCDAB89;
			3'd2: v = 32'h98BADCFE;
			3'd3: v = 32'h10325476;
			3'd4: v = 32'hC3D2E1F0;
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic word_t round_k(rnd_t r);
		word_t k;
		if (r inside {[7'd0:7'd19]}) begin
			k = 32'h5A827999;
		end else if (r inside {[7'd20:7'd39]}) begin
			k = 32'h6ED9EBA1;
		end else if (r inside {[7'd40:7'd59]}) begin
			k = 32'h8F1BBCDC;
		end else begin
			k = 32'hCA62C1D6;
		end
		return k;
	endfunction

	function automatic word_t round_f(rnd_t r, word_t b, word_t c, word_t d);
		word_t f;
		if (r inside {[7'd0:7'd19]}) begin
			f = (b & c) | (~b & d);
		end else if (r inside {[7'd40:7'd59]}) begin
			f = (b & c) | (b & d) | (c & d);
		end else begin
			f = b ^ c ^ d;
		end
		return f;
	endfunction

endpackage

// File: src/sha1ba_blk_mem.sv
`timescale 1ns / 1ps

module sha1ba_blk_mem (
	input  logic              clk,
	input  logic              we,
	input  sha1ba_pkg::pos_t  wpos,
	input  logic [7:0]        wbyte,
	input  logic              re,
	input  sha1ba_pkg::maddr_t raddr,
	output sha1ba_pkg::word_t rdata
);
	import sha1ba_pkg::*;

	word_t mem_q [BLK_WORDS];
	word_t rdata_q;

	// big-endian: byte 0 of a word sits in the top lane
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wpos[5:2]][{~wpos[1:0], 3'b000} +: 8] <= wbyte;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: src/sha1ba_chain_mem.sv
`timescale 1ns / 1ps

module sha1ba_chain_mem (
	input  logic              clk,
	input  logic              we,
	input  sha1ba_pkg::widx_t waddr,
	input  sha1ba_pkg::word_t wdata,
	input  logic              re,
	input  sha1ba_pkg::widx_t raddr,
	output sha1ba_pkg::word_t rdata
);
	import sha1ba_pkg::*;

	word_t mem_q [NUM_WORDS];
	word_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: src/sha1ba_round.sv
`timescale 1ns / 1ps

module sha1ba_round (
	input  logic              clk,
	input  sha1ba_pkg::rctl_t ctl,
	input  sha1ba_pkg::word_t load_word,
	input  sha1ba_pkg::word_t msg_word,
	output sha1ba_pkg::work_t work
);
	import sha1ba_pkg::*;

	work_t work_q;
	word_t win_q [BLK_WORDS];
	word_t w_mix;
	word_t w_cur;
	word_t t_sum;

	always_comb begin
		w_mix = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
		if (ctl.rnd < rnd_t'(BLK_WORDS)) begin
			w_cur = msg_word;
		end else begin
			w_cur = {w_mix[30:0], w_mix[31]};
		end
		t_sum = {work_q.a[26:0], work_q.a[31:27]}
			+ round_f(ctl.rnd, work_q.b, work_q.c, work_q.d)
			+ work_q.e + round_k(ctl.rnd) + w_cur;
	end

	always_ff @(posedge clk) begin
		if (ctl.load_en) begin
			case (ctl.load_idx)
				3'd0: work_q.a <= load_word;
				3'd1: work_q.b <= load_word;
				3'd2: work_q.c <= load_word;
				3'd3: work_q.d <= load_word;
				3'd4: work_q.e <= load_word;
				default: ;
			endcase
		end else if (ctl.round_en) begin
			work_q.a <= t_sum;
			work_q.b <= work_q.a;
			work_q.c <= {work_q.b[1:0], work_q.b[31:2]};
			work_q.d <= work_q.c;
			work_q.e <= work_q.d;
			for (int i = 0; i < BLK_WORDS - 1; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[BLK_WORDS - 1] <= w_cur;
		end
	end

	assign work = work_q;

endmodule

// File: src/sha1_block_absorber_core.sv
// SHA-1 block absorber: one message byte per request, one full 80-round
// compression each time the 64-byte block fills.
// Byte channel (byte_valid/byte_stall, kind, data_byte): kind 0 starts a new
// message (initial chaining words, position 0), kind 1 stores data_byte at
// the current position. Bytes are taken one per cycle while idle.
// Word channel (word_valid/word_stall, word_index, chain_word, last_word):
// after the 64th byte the block stalls the byte channel, loads the chaining
// words, runs 80 rounds at one round per cycle, then reads, adds and
// writes back each chaining word through the chaining memory, a read in
// ST_FRD and an add and write in ST_FWR per word. Words follow in index
// order 0 to 4; last_word marks word 4.
// A stalled word holds in the output register and the block waits before
// writing back the next word; the byte channel stays stalled until the
// fifth word is in the output register.
// Reset: position 0, chaining words read as the initial values, no word
// pending; no clearing pass is needed.
`timescale 1ns / 1ps
`include "sha1_block_absorber_core_defines.svh"

module sha1_block_absorber_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	output logic              byte_stall,
	input  logic              kind,
	input  logic [7:0]        data_byte,
	output logic              word_valid,
	input  logic              word_stall,
	output logic [2:0]        word_index,
	output logic [31:0]       chain_word,
	output logic              last_word
);
	import sha1ba_pkg::*;

	state_t state_q;
	state_t state_nx;
	widx_t  ld_cnt_q;
	rnd_t   rnd_q;
	widx_t  wsel_q;
	pos_t   pos_q;
	logic   iv_pend_q;

	logic   word_valid_q;
	widx_t  word_index_q;
	word_t  chain_word_q;
	logic   last_word_q;

	logic   byte_acc;
	logic   data_acc;
	logic   slot_free;
	logic   out_load;
	logic   ch_re;
	widx_t  ch_raddr;
	logic   ch_we;
	word_t  ch_rdata;
	logic   bm_re;
	maddr_t bm_raddr;
	word_t  bm_rdata;
	rctl_t  rctl;
	widx_t  prev_idx;
	widx_t  chain_idx;
	word_t  chain_val;
	word_t  work_sel;
	word_t  sum;
	work_t  work;

	assign byte_stall = (state_q != ST_IDLE);
	assign byte_acc   = byte_valid && !byte_stall;
	assign data_acc   = byte_acc && (kind_t'(kind) == KIND_DATA);
	assign slot_free  = !word_valid_q || !word_stall;
	assign prev_idx   = ld_cnt_q - 3'd1;

	sha1ba_blk_mem u_blk_mem (
		.clk   (clk),
		.we    (data_acc),
		.wpos  (pos_q),
		.wbyte (data_byte),
		.re    (bm_re),
		.raddr (bm_raddr),
		.rdata (bm_rdata)
	);

	sha1ba_chain_mem u_chain_mem (
		.clk   (clk),
		.we    (ch_we),
		.waddr (wsel_q),
		.wdata (sum),
		.re    (ch_re),
		.raddr (ch_raddr),
		.rdata (ch_rdata)
	);

	sha1ba_round u_round (
		.clk       (clk),
		.ctl       (rctl),
		.load_word (chain_val),
		.msg_word  (bm_rdata),
		.work      (work)
	);

	always_comb begin
		chain_idx = (state_q == ST_FWR) ? wsel_q : prev_idx;
		chain_val = iv_pend_q ? iv_word(chain_idx) : ch_rdata;
		case (wsel_q)
			3'd0: work_sel = work.a;
			3'd1: work_sel = work.b;
			3'd2: work_sel = work.c;
			3'd3: work_sel = work.d;
			default: work_sel = work.e;
		endcase
		sum = chain_val + work_sel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx      = state_q;
		ch_re         = 1'b0;
		ch_raddr      = ld_cnt_q;
		ch_we         = 1'b0;
		bm_re         = 1'b0;
		bm_raddr      = '0;
		rctl          = '0;
		rctl.rnd      = rnd_q;
		rctl.load_idx = prev_idx;
		out_load      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (data_acc && pos_q == LAST_POS) begin
					state_nx = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (ld_cnt_q != LOAD_DONE) begin
					ch_re = 1'b1;
				end
				if (ld_cnt_q != '0) begin
					rctl.load_en = 1'b1;
				end
				if (ld_cnt_q == LOAD_DONE) begin
					bm_re    = 1'b1;
					state_nx = ST_ROUND;
				end
			end
			ST_ROUND: begin
				rctl.round_en = 1'b1;
				if (rnd_q < rnd_t'(LAST_MWORD)) begin
					bm_re    = 1'b1;
					bm_raddr = maddr_t'(rnd_q + 7'd1);
				end
				if (rnd_q == LAST_RND) begin
					state_nx = ST_FRD;
				end
			end
			ST_FRD: begin
				ch_re    = 1'b1;
				ch_raddr = wsel_q;
				state_nx = ST_FWR;
			end
			ST_FWR: begin
				if (slot_free) begin
					out_load = 1'b1;
					ch_we    = 1'b1;
					state_nx = (wsel_q == LAST_IDX) ? ST_IDLE : ST_FRD;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_cnt_q     <= '0;
			rnd_q        <= '0;
			wsel_q       <= '0;
			pos_q        <= '0;
			iv_pend_q    <= 1'b1;
			word_valid_q <= 1'b0;
		end else begin
			ld_cnt_q <= (state_q == ST_LOAD) ? ld_cnt_q + 3'd1 : '0;
			rnd_q    <= (state_q == ST_ROUND) ? rnd_q + 7'd1 : '0;
			if (out_load) begin
				wsel_q <= (wsel_q == LAST_IDX) ? '0 : wsel_q + 3'd1;
			end
			if (byte_acc) begin
				pos_q <= data_acc ? pos_q + 6'd1 : '0;
			end
			if (byte_acc && !data_acc) begin
				iv_pend_q <= 1'b1;
			end else if (out_load && wsel_q == LAST_IDX) begin
				iv_pend_q <= 1'b0;
			end
			if (out_load) begin
				word_valid_q <= 1'b1;
			end else if (!word_stall) begin
				word_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			word_index_q <= wsel_q;
			chain_word_q <= sum;
			last_word_q  <= (wsel_q == LAST_IDX);
		end
	end

	assign word_valid = word_valid_q;
	assign word_index = word_index_q;
	assign chain_word = chain_word_q;
	assign last_word  = last_word_q;

	`SHA1BA_ASSERT_IMPLIES(a_new_word_from_wb, $rose(word_valid_q), $past(state_q) == ST_FWR, "word appeared outside write-back")
	`SHA1BA_ASSERT_IMPLIES(a_last_flag, word_valid_q, last_word_q == (word_index_q == LAST_IDX), "last_word does not match word_index")
	`SHA1BA_ASSERT_IMPLIES(a_round_range, state_q == ST_ROUND, rnd_q < rnd_t'(ROUNDS), "round counter out of range")
	`SHA1BA_ASSERT_NEVER(a_pos_wrapped, state_q == ST_LOAD && ld_cnt_q == '0 && pos_q != '0, "position did not wrap on full block")

endmodule
